// ===== design/ssl_pkg.sv =====
`default_nettype none

package ssl_pkg;

  // Default geometry
  localparam int DEPTH      = 128;
  localparam int NAME_BYTES = 8;

  // Fixed field widths
  localparam int KEY_W    = 64;
  localparam int LINE_W   = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int DIST_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_LOOKUP = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_REDEFINED = 3'd3,
    ST_UNDEFINED = 3'd4
  } status_e;

  // One stack entry as held in the store
  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [KEY_W-1:0]  key;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/ssl_store.sv =====
`default_nettype none

// Entry store: one write port, one read port, read data registered.
module ssl_store #(
  parameter int DEPTH = ssl_pkg::DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  wire ssl_pkg::entry_t wr_entry_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output ssl_pkg::entry_t      rd_entry_o
);

  ssl_pkg::entry_t mem [DEPTH];
  ssl_pkg::entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_q;

endmodule

`default_nettype wire

// ===== design/scoped_symbol_stack_lookup_core.sv =====
`default_nettype none

// Scoped symbol stack with top-down search.
//
// Input channel: a command word (command_i, name_key_i, line_number_i) is
// taken at a rising edge where start is high and busy is low.
// Output channel: each command yields exactly one result word on status_o,
// distance_o and earlier_line_o, marked by valid_o for a single cycle. The
// receiver cannot stall; the word is gone after that cycle.
//
// Push and pop: the result shows the next cycle and a new word may be taken in
// that same cycle. A check or lookup walks the entry store from the top, one
// synchronous read per cycle, until a match or the bottom of the stack; on an
// empty stack it answers like a push or pop. The single read port of the store
// sets the pace of the walk.
//
// Reset clears the entry count and the control state; store contents stay
// undefined and are only read below the count. Writes and searches never
// overlap in time, so the store needs no forwarding.
module scoped_symbol_stack_lookup_core #(
  parameter int DEPTH      = ssl_pkg::DEPTH,
  parameter int NAME_BYTES = ssl_pkg::NAME_BYTES
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [ssl_pkg::CMD_W-1:0]    command_i,
  input  wire logic [ssl_pkg::KEY_W-1:0]    name_key_i,
  input  wire logic [ssl_pkg::LINE_W-1:0]   line_number_i,
  output      logic                         valid_o,
  output      logic [ssl_pkg::STATUS_W-1:0] status_o,
  output      logic [ssl_pkg::DIST_W-1:0]   distance_o,
  output      logic [ssl_pkg::LINE_W-1:0]   earlier_line_o
);

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int KeyW   = ssl_pkg::KEY_W;
  localparam int DistW  = ssl_pkg::DIST_W;
  localparam int LineW  = ssl_pkg::LINE_W;
  localparam logic [KeyW-1:0] KeyMask = {KeyW{1'b1}} >> (KeyW - 8 * NAME_BYTES);
  localparam logic [CW-1:0]   Full    = CW'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e                       state_q, state_d;
  logic [CW-1:0]                count_q, count_d;
  logic [AW-1:0]                dist_q, dist_d;
  ssl_pkg::cmd_e                cmd_q, cmd_d;
  logic [KeyW-1:0]              key_q, key_d;
  logic                         valid_q, valid_d;
  ssl_pkg::status_e             status_q, status_d;
  logic [AW-1:0]                res_dist_q, res_dist_d;
  logic [LineW-1:0]             earlier_q, earlier_d;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  ssl_pkg::entry_t              wr_entry;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  ssl_pkg::entry_t              rd_entry;

  logic                         accept;
  logic [CW-1:0]                top_idx;
  logic [CW-1:0]                dist_next;
  logic [CW-1:0]                next_addr;
  logic                         hit;

  assign accept    = start && !busy;
  assign top_idx   = count_q - CW'(1);
  assign dist_next = CW'(dist_q) + CW'(1);
  assign next_addr = top_idx - dist_next;
  assign hit       = (rd_entry.key == key_q);

  ssl_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_entry_i (wr_entry),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .rd_entry_o (rd_entry)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    dist_d     = dist_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    valid_d    = 1'b0;
    status_d   = status_q;
    res_dist_d = res_dist_q;
    earlier_d  = earlier_q;

    wr_en          = 1'b0;
    wr_addr        = count_q[AW-1:0];
    wr_entry.key   = name_key_i & KeyMask;
    wr_entry.line  = line_number_i;
    rd_en          = 1'b0;
    rd_addr        = top_idx[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d      = ssl_pkg::cmd_e'(command_i);
          key_d      = name_key_i & KeyMask;
          status_d   = ssl_pkg::ST_OK;
          res_dist_d = '0;
          earlier_d  = '0;
          case (ssl_pkg::cmd_e'(command_i))
            ssl_pkg::CMD_PUSH: begin
              valid_d = 1'b1;
              if (count_q == Full) begin
                status_d = ssl_pkg::ST_OVERFLOW;
              end else begin
                wr_en   = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            ssl_pkg::CMD_POP: begin
              valid_d = 1'b1;
              if (count_q == '0) begin
                status_d = ssl_pkg::ST_UNDERFLOW;
              end else begin
                count_d = top_idx;
              end
            end
            default: begin
              // Check and lookup both walk the stack from the top
              if (count_q == '0) begin
                valid_d = 1'b1;
                if (ssl_pkg::cmd_e'(command_i) == ssl_pkg::CMD_LOOKUP) begin
                  status_d = ssl_pkg::ST_UNDEFINED;
                end
              end else begin
                rd_en   = 1'b1;
                dist_d  = '0;
                state_d = S_SEARCH;
              end
            end
          endcase
        end
      end
      S_SEARCH: begin
        // Compare the word read last cycle; prefetch the next one below it
        if (hit) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
          if (cmd_q == ssl_pkg::CMD_CHECK) begin
            status_d  = ssl_pkg::ST_REDEFINED;
            earlier_d = rd_entry.line;
          end else begin
            res_dist_d = dist_q;
          end
        end else if (dist_next == count_q) begin
          valid_d = 1'b1;
          state_d = S_IDLE;
          if (cmd_q == ssl_pkg::CMD_LOOKUP) begin
            status_d = ssl_pkg::ST_UNDEFINED;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = next_addr[AW-1:0];
          dist_d  = dist_next[AW-1:0];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      valid_q    <= 1'b0;
      dist_q     <= '0;
      cmd_q      <= ssl_pkg::CMD_PUSH;
      key_q      <= '0;
      status_q   <= ssl_pkg::ST_OK;
      res_dist_q <= '0;
      earlier_q  <= '0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      valid_q    <= valid_d;
      dist_q     <= dist_d;
      cmd_q      <= cmd_d;
      key_q      <= key_d;
      status_q   <= status_d;
      res_dist_q <= res_dist_d;
      earlier_q  <= earlier_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign distance_o     = DistW'(res_dist_q);
  assign earlier_line_o = earlier_q;

  // The count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Full)
    else $error("entry count beyond depth");

  // A search only runs over a nonempty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH) |-> (count_q != '0))
    else $error("search on empty stack");

  // Push and pop answer in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == ssl_pkg::CMD_PUSH || command_i == ssl_pkg::CMD_POP))
      |=> (valid_o && !busy))
    else $error("push or pop result missing");

  // The count moves only on an accepted word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(accept))
    else $error("entry count moved without a command");

endmodule

`default_nettype wire
